// ===== rtl/core/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer package
// Shared types, register indexes and the tangent table for the arc limit test.
// ----------------------------------------------------------------------------
package mar_pkg;

  // Configuration register indexes.
  localparam logic REG_RADIUS    = 1'b0;
  localparam logic REG_ARC_ANGLE = 1'b1;

  // Angle handling.
  localparam int ANGLE_W     = 9;
  localparam int OCT_W       = 4;
  localparam int REM_W       = 6;
  localparam int NUM_OCT     = 8;
  localparam int ANGLE_STEP  = 45;
  // Reciprocal of 45 scaled by 2^15; exact for every 9-bit angle.
  localparam int RECIP_MUL   = 729;
  localparam int RECIP_W     = 10;
  localparam int RECIP_SHIFT = 15;

  // Tangent table precision.
  localparam int TAN_TABLE_FRAC = 16;

  // Per-step control passed from the front end to the back end.
  typedef struct packed {
    logic               idle;  // advance with no arc in progress
    logic               done;  // arc complete after this step
    logic [NUM_OCT-1:0] keep;  // per-octant point kept flags
  } step_flags_t;

  // tan(deg) for deg = 0..44, rounded to 16 fraction bits.
  function automatic logic [TAN_TABLE_FRAC-1:0] tan_q16(input logic [REM_W-1:0] deg);
    logic [TAN_TABLE_FRAC-1:0] t;
    case (deg)
      6'd0:  t = 16'd0;
      6'd1:  t = 16'd1144;
      6'd2:  t = 16'd2289;
      6'd3:  t = 16'd3435;
      6'd4:  t = 16'd4583;
      6'd5:  t = 16'd5734;
      6'd6:  t = 16'd6888;
      6'd7:  t = 16'd8047;
      6'd8:  t = 16'd9210;
      6'd9:  t = 16'd10380;
      6'd10: t = 16'd11556;
      6'd11: t = 16'd12739;
      6'd12: t = 16'd13930;
      6'd13: t = 16'd15130;
      6'd14: t = 16'd16340;
      6'd15: t = 16'd17560;
      6'd16: t = 16'd18792;
      6'd17: t = 16'd20036;
      6'd18: t = 16'd21294;
      6'd19: t = 16'd22566;
      6'd20: t = 16'd23853;
      6'd21: t = 16'd25157;
      6'd22: t = 16'd26478;
      6'd23: t = 16'd27818;
      6'd24: t = 16'd29179;
      6'd25: t = 16'd30560;
      6'd26: t = 16'd31964;
      6'd27: t = 16'd33392;
      6'd28: t = 16'd34846;
      6'd29: t = 16'd36327;
      6'd30: t = 16'd37837;
      6'd31: t = 16'd39378;
      6'd32: t = 16'd40951;
      6'd33: t = 16'd42560;
      6'd34: t = 16'd44205;
      6'd35: t = 16'd45889;
      6'd36: t = 16'd47615;
      6'd37: t = 16'd49385;
      6'd38: t = 16'd51202;
      6'd39: t = 16'd53070;
      6'd40: t = 16'd54991;
      6'd41: t = 16'd56970;
      6'd42: t = 16'd59009;
      6'd43: t = 16'd61113;
      6'd44: t = 16'd63287;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/mar_queue.sv =====
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer step queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mar_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head_data = mem[rd_ptr];
  assign not_empty = (count != '0);

  // The front end must never overrun the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(DEPTH))
    else $error("step queue overflow");

  // The back end must never take from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("step queue underflow");

endmodule

// ===== rtl/core/mar_front.sv =====
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer front end
// Accepts step items, advances the midpoint walker and classifies the octants.
// ----------------------------------------------------------------------------
module mar_front #(
  parameter int COORD_BITS    = 10,
  parameter int TAN_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             restart,
  input  logic [COORD_BITS-1:0]            radius,
  input  logic [mar_pkg::OCT_W-1:0]        arc_oct,
  input  logic [TAN_FRAC_BITS-1:0]         limit_slope,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
  output logic                             push,
  output logic [COORD_BITS-1:0]            push_x,
  output logic [COORD_BITS-1:0]            push_y,
  output mar_pkg::step_flags_t             push_flags
);

  import mar_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int TF    = TAN_FRAC_BITS;
  localparam int DW    = CB + 3;
  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam int PW    = CB + TF + 1;

  // Walker state.
  logic [CB-1:0] cur_x, cur_x_next;
  logic [CB-1:0] cur_y, cur_y_next;
  logic [DW-1:0] decision, decision_next;
  logic          active, active_next;
  logic          step_idle;
  logic          step_done;
  logic          accept;

  // Snapshot stage feeding the octant tests.
  logic          a_valid;
  logic [CB-1:0] a_x;
  logic [CB-1:0] a_y;
  logic          a_idle;
  logic          a_done;
  logic [OCT_W-1:0] a_oct;
  logic [TF-1:0] a_slope;

  // Accept while the queue has room for this item and the one in flight.
  assign in_stall = ((CNT_W+1)'(q_count) + (CNT_W+1)'(a_valid)) >= (CNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  // One midpoint iteration, a restart, or an idle advance.
  always_comb begin
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    decision_next = decision;
    step_idle     = 1'b0;
    if (restart) begin
      cur_x_next    = '0;
      cur_y_next    = radius;
      decision_next = DW'(1) - DW'(radius);
    end else if (!active || (cur_y <= cur_x)) begin
      step_idle = 1'b1;
    end else begin
      if (decision[DW-1]) begin
        decision_next = decision + DW'({cur_x, 1'b0}) + DW'(3);
      end else begin
        decision_next = decision + ((DW'(cur_x) - DW'(cur_y)) << 1) + DW'(5);
        cur_y_next    = cur_y - CB'(1);
      end
      cur_x_next = cur_x + CB'(1);
    end
    step_done   = step_idle || !(cur_y_next > cur_x_next);
    active_next = !step_done;
  end

  // Walker registers and snapshot stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x    <= '0;
      cur_y    <= '0;
      decision <= '0;
      active   <= 1'b0;
      a_valid  <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        cur_x    <= cur_x_next;
        cur_y    <= cur_y_next;
        decision <= decision_next;
        active   <= active_next;
      end
    end
  end

  // Snapshot payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_x     <= step_idle ? '0 : cur_x_next;
      a_y     <= step_idle ? '0 : cur_y_next;
      a_idle  <= step_idle;
      a_done  <= step_done;
      a_oct   <= arc_oct;
      a_slope <= limit_slope;
    end
  end

  // Angle limit tests on the new position.
  logic [PW-1:0] even_lhs;
  logic [PW-1:0] even_rhs;
  logic [TF:0]   s_minus;
  logic [TF:0]   s_plus;
  logic [PW-1:0] odd_lhs;
  logic [PW-1:0] odd_rhs;
  logic          even_ok;
  logic          odd_ok;

  always_comb begin
    even_lhs = PW'(a_y) * PW'(a_slope);
    even_rhs = PW'({a_x, {TF{1'b0}}});
    s_minus  = {1'b1, {TF{1'b0}}} - {1'b0, a_slope};
    s_plus   = {1'b1, a_slope};
    odd_lhs  = PW'(a_y) * PW'(s_minus);
    odd_rhs  = PW'(a_x) * PW'(s_plus);
    even_ok  = ((a_x == '0) && (a_y != '0)) || (even_lhs > even_rhs);
    odd_ok   = (odd_lhs <= odd_rhs);
  end

  // Per-octant keep flags and queue write.
  always_comb begin
    push_flags.idle = a_idle;
    push_flags.done = a_done;
    for (int i = 0; i < NUM_OCT; i++) begin
      push_flags.keep[i] = (a_oct > OCT_W'(i)) ||
                           ((a_oct == OCT_W'(i)) && (((i & 1) != 0) ? odd_ok : even_ok));
    end
  end

  assign push   = a_valid;
  assign push_x = a_x;
  assign push_y = a_y;

endmodule

// ===== rtl/core/mar_back.sv =====
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer back end
// Expands each queued step into its symmetric points, one result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module mar_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [COORD_BITS-1:0]       head_x,
  input  logic [COORD_BITS-1:0]       head_y,
  input  mar_pkg::step_flags_t        head_flags,
  input  logic                        q_not_empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COORD_BITS:0]  point_x,
  output logic signed [COORD_BITS:0]  point_y,
  output logic                        point_valid,
  output logic                        last_of_step,
  output logic                        arc_done
);

  import mar_pkg::*;

  localparam int OW = COORD_BITS + 1;

  logic [2:0]          sub_idx, sub_idx_next;
  logic                load;
  logic                res_last;
  logic signed [OW-1:0] pos_x, pos_y, neg_x, neg_y;
  logic signed [OW-1:0] res_x, res_y;
  logic                res_valid;

  // Load a new result whenever the queue holds a step and the output register is free or being taken.
  assign load     = q_not_empty && (!out_valid || !out_stall);
  assign res_last = head_flags.idle || (sub_idx == 3'd7);
  assign pop      = load && res_last;

  always_comb begin
    sub_idx_next = sub_idx;
    if (load) begin
      sub_idx_next = res_last ? 3'd0 : sub_idx + 3'd1;
    end
  end

  // Point of the current octant.
  always_comb begin
    pos_x = $signed({1'b0, head_x});
    pos_y = $signed({1'b0, head_y});
    neg_x = -pos_x;
    neg_y = -pos_y;
    case (sub_idx)
      3'd0: begin res_x = pos_x; res_y = neg_y; end
      3'd1: begin res_x = pos_y; res_y = neg_x; end
      3'd2: begin res_x = pos_y; res_y = pos_x; end
      3'd3: begin res_x = pos_x; res_y = pos_y; end
      3'd4: begin res_x = neg_x; res_y = pos_y; end
      3'd5: begin res_x = neg_y; res_y = pos_x; end
      3'd6: begin res_x = neg_y; res_y = neg_x; end
      3'd7: begin res_x = neg_x; res_y = neg_y; end
      default: begin res_x = '0; res_y = '0; end
    endcase
    res_valid = head_flags.keep[sub_idx];
    if (head_flags.idle) begin
      res_x     = '0;
      res_y     = '0;
      res_valid = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      sub_idx <= sub_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      point_x      <= res_x;
      point_y      <= res_y;
      point_valid  <= res_valid;
      last_of_step <= res_last;
      arc_done     <= head_flags.done;
    end
  end

  // A step's results follow each other without a gap.
  a_step_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_step |=> out_valid)
    else $error("gap inside a step's results");

  // All results of one step carry the same completion flag.
  a_done_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_step |=> $stable(arc_done))
    else $error("completion flag changed within a step");

endmodule

// ===== rtl/core/midpoint_arc_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer
// Walks a circle arc by the midpoint method and emits its symmetric points.
// ----------------------------------------------------------------------------
// Usage:
//   Write radius (index 0) and arc_angle (index 1) through the cfg port while
//   the block is idle. Each input transfer carries restart: 1 places the
//   walker at (0, radius), 0 advances one midpoint iteration.
//   Every stepping item yields eight results, one per octant, with
//   last_of_step on the eighth; an advance with no arc in progress yields a
//   single empty result with last_of_step and arc_done set.
// Pipeline and throughput:
//   The first result of an item passes the snapshot stage, the step queue
//   and the output register. The result register delivers one result per
//   cycle while out_stall is low, setting the item rate. The step queue lets
//   the input take up to QUEUE_DEPTH items ahead while results drain.
// Reset and stall:
//   rst clears the walker, the queue and the output register; radius and
//   arc_angle return to zero. When out_stall is high the current result holds
//   and the queue fills; in_stall rises once the queue has no room left.
// ----------------------------------------------------------------------------
module midpoint_arc_rasterizer_unit #(
  parameter int COORD_BITS    = 10,
  parameter int TAN_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [((COORD_BITS > mar_pkg::ANGLE_W) ? COORD_BITS : mar_pkg::ANGLE_W)-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         point_valid,
  output logic                         last_of_step,
  output logic                         arc_done
);

  import mar_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int TF      = TAN_FRAC_BITS;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH+1);
  localparam int FLAGS_W = $bits(step_flags_t);
  localparam int QW      = 2 * CB + FLAGS_W;
  localparam int SHL     = (TF >= TAN_TABLE_FRAC) ? TF - TAN_TABLE_FRAC : 0;
  localparam int SHR     = (TF < TAN_TABLE_FRAC) ? TAN_TABLE_FRAC - TF : 0;
  localparam int RND_ADD = (SHR > 0) ? (1 << (SHR - 1)) : 0;
  localparam int TW      = TAN_TABLE_FRAC + SHL + 1;
  localparam int PROD_W  = ANGLE_W + RECIP_W;

  // Configuration registers.
  logic [CB-1:0]    radius;
  logic [OCT_W-1:0] arc_oct;
  logic [TF-1:0]    limit_slope;

  // Split the written angle into octant and remainder, then look up the slope.
  logic [ANGLE_W-1:0] new_angle;
  logic [PROD_W-1:0]  angle_prod;
  logic [OCT_W-1:0]   new_oct;
  logic [ANGLE_W-1:0] oct_base;
  logic [REM_W-1:0]   new_rem;
  logic [TW-1:0]      tan_wide;
  logic [TW-1:0]      tan_rounded;
  logic [TF-1:0]      new_slope;

  always_comb begin
    new_angle   = cfg_data[ANGLE_W-1:0];
    angle_prod  = PROD_W'(new_angle) * PROD_W'(RECIP_MUL);
    new_oct     = angle_prod[RECIP_SHIFT +: OCT_W];
    oct_base    = ANGLE_W'(ANGLE_W'(new_oct) * ANGLE_W'(ANGLE_STEP));
    new_rem     = REM_W'(new_angle - oct_base);
    tan_wide    = TW'(tan_q16(new_rem));
    tan_rounded = (tan_wide + TW'(RND_ADD)) >> SHR;
    new_slope   = TF'(tan_rounded << SHL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= '0;
      arc_oct     <= '0;
      limit_slope <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS: begin
          radius <= cfg_data[CB-1:0];
        end
        REG_ARC_ANGLE: begin
          arc_oct     <= new_oct;
          limit_slope <= new_slope;
        end
        default: begin
        end
      endcase
    end
  end

  // Front end to queue.
  logic                push;
  logic [CB-1:0]       push_x;
  logic [CB-1:0]       push_y;
  step_flags_t         push_flags;
  logic [CNT_W-1:0]    q_count;
  logic                q_not_empty;
  logic                pop;
  logic [QW-1:0]       head_data;
  logic [CB-1:0]       head_x;
  logic [CB-1:0]       head_y;
  step_flags_t         head_flags;

  mar_front #(
    .COORD_BITS    (COORD_BITS),
    .TAN_FRAC_BITS (TAN_FRAC_BITS),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .radius      (radius),
    .arc_oct     (arc_oct),
    .limit_slope (limit_slope),
    .q_count     (q_count),
    .push        (push),
    .push_x      (push_x),
    .push_y      (push_y),
    .push_flags  (push_flags)
  );

  mar_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_x, push_y, push_flags}),
    .pop       (pop),
    .head_data (head_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign {head_x, head_y, head_flags} = head_data;

  mar_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_x       (head_x),
    .head_y       (head_y),
    .head_flags   (head_flags),
    .q_not_empty  (q_not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_valid  (point_valid),
    .last_of_step (last_of_step),
    .arc_done     (arc_done)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint arc rasterizer testbench
// Drives restart and advance transfers through the arc walker and checks each
// emitted octant point against a cycle-free model of the midpoint walk and of
// the tangent-based arc limit. A directed table covers the corner cases, and
// random arcs with random radius and angle settings follow. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module tb;
  import mar_pkg::*;

  localparam int CFG_W      = 10;
  localparam int PT_W       = 11;
  localparam int TAN_FRAC   = 16;
  localparam int DRAIN_WAIT = 4;
  localparam int STALL_PCT  = 33;
  localparam int ITEM_GOAL  = 400;
  localparam int DOG_LIMIT  = 3000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table. Rows marked typed carry their expected
  // points by hand: an advance gives the empty point, and a restart assumes
  // radius zero, so every octant sits at the origin with the given keep mask.
  typedef struct packed {
    row_kind_t         kind;
    logic              idx;
    logic [CFG_W-1:0]  data;
    logic              rs;
    logic              typed;
    logic [7:0]        keep_mask;
  } stim_row_t;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   pv;
    logic                   last;
    logic                   done;
  } arc_point_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic                    cfg_index = 1'b0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [PT_W-1:0]  point_x;
  logic signed [PT_W-1:0]  point_y;
  logic                    point_valid;
  logic                    last_of_step;
  logic                    arc_done;

  // Tangent of 0..44 degrees with 16 fraction bits.
  int unsigned tan_deg_q16 [45] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
    23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
    37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
    54991, 56970, 59009, 61113, 63287
  };

  // Walker model state and its copy of the registers.
  logic [CFG_W-1:0] cfg_radius = '0;
  logic [8:0]       cfg_angle = '0;
  longint unsigned  lim_slope = 0;
  logic [CFG_W-1:0] walk_x = '0;
  logic [CFG_W-1:0] walk_y = '0;
  int               walk_d = 0;
  logic             walk_on = 1'b0;

  arc_point_t queued_points [$];
  arc_point_t step_points [$];
  int         items_sent = 0;
  int         fail_count = 0;
  int         idle_cycles = 0;
  logic       calm = 1'b0;

  midpoint_arc_rasterizer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_valid  (point_valid),
    .last_of_step (last_of_step),
    .arc_done     (arc_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Works out the points of one walker step into step_points.
  task automatic plot_octants(input logic rs);
    int              xi;
    int              yi;
    int              oct;
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned full;
    logic            even_ok;
    logic            odd_ok;
    logic            done;
    arc_point_t      pt;
    int              xs [8];
    int              ys [8];
    step_points.delete();
    if (rs) begin
      walk_x  = '0;
      walk_y  = cfg_radius;
      walk_d  = 1 - int'(cfg_radius);
      walk_on = 1'b1;
    end else begin
      // An advance with no arc in progress gives the single empty point.
      if (!walk_on || walk_y <= walk_x) begin
        walk_on = 1'b0;
        pt.px = '0;
        pt.py = '0;
        pt.pv = 1'b0;
        pt.last = 1'b1;
        pt.done = 1'b1;
        step_points = {step_points, pt};
        return;
      end
      if (walk_d < 0) begin
        walk_d += 2 * int'(walk_x) + 3;
      end else begin
        walk_d += 2 * (int'(walk_x) - int'(walk_y)) + 5;
        walk_y = walk_y - 1'b1;
      end
      walk_x = walk_x + 1'b1;
    end
    done = !(walk_y > walk_x);
    if (done) begin
      walk_on = 1'b0;
    end

    // Eight mirrored points; the octant holding the arc end is cut by the
    // tangent of the angle remainder.
    xi = int'(walk_x);
    yi = int'(walk_y);
    xs = '{xi, yi, yi, xi, -xi, -yi, -yi, -xi};
    ys = '{-yi, -xi, xi, yi, yi, xi, -xi, -yi};
    ux = walk_x;
    uy = walk_y;
    full = 64'd1 << TAN_FRAC;
    even_ok = (walk_x == 0 && walk_y > 0) || (uy * lim_slope > ux * full);
    odd_ok  = uy * (full - lim_slope) <= ux * (full + lim_slope);
    oct = int'(cfg_angle) / ANGLE_STEP;
    for (int i = 0; i < NUM_OCT; i++) begin
      pt.px = PT_W'(xs[i]);
      pt.py = PT_W'(ys[i]);
      pt.pv = (oct > i) || (oct == i && ((i % 2 == 1) ? odd_ok : even_ok));
      pt.last = (i == NUM_OCT - 1);
      pt.done = done;
      step_points = {step_points, pt};
    end
  endtask

  // Writes one register once every queued point has come out.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (queued_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_RADIUS) begin
      cfg_radius = val;
    end else begin
      cfg_angle = val[8:0];
      lim_slope = tan_deg_q16[int'(cfg_angle) % ANGLE_STEP];
    end
  endtask

  // Sends one input transfer and queues the points it should cause.
  task automatic send_item(input logic rs, input logic typed, input logic [7:0] keep_mask);
    logic       quiet;
    arc_point_t pt;
    quiet = (items_sent >= 180 && items_sent < 260);
    calm <= quiet;
    if (!quiet) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        restart  <= 1'($urandom_range(1));
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    plot_octants(rs);
    if (!typed) begin
      queued_points = {queued_points, step_points};
    end else if (!rs) begin
      pt = '0;
      pt.last = 1'b1;
      pt.done = 1'b1;
      queued_points = {queued_points, pt};
    end else begin
      for (int i = 0; i < NUM_OCT; i++) begin
        pt = '0;
        pt.pv = keep_mask[i];
        pt.last = (i == NUM_OCT - 1);
        pt.done = 1'b1;
        queued_points = {queued_points, pt};
      end
    end
  endtask

  // Stimulus: directed table, then random arcs.
  initial begin
    stim_row_t plan [$];
    int        pick;
    int        steps;
    int        ang;
    plan = '{
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b1, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b1, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b1, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd360,  1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b1, 8'hFF},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'h1FF,  1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b1, 8'hFF},
      '{ROW_CFG,  REG_RADIUS,    10'd1023, 1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'h3FF,  1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd45,   1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd134,  1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_RADIUS,    10'd3,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b1, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd359,  1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_RADIUS,    10'd7,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  REG_ARC_ANGLE, 10'd90,   1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00},
      '{ROW_ITEM, REG_RADIUS,    10'd0,    1'b1, 1'b0, 8'h00}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases: idle advances, zero radius, full and masked
    // angles, maximum radius, exact octant boundaries and mid-arc writes.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_item(plan[r].rs, plan[r].typed, plan[r].keep_mask);
      end
    end

    // Random arcs, mostly walked to completion with small radii.
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          write_reg(REG_RADIUS, CFG_W'($urandom_range(0, 40)));
        end else if (pick < 90) begin
          write_reg(REG_RADIUS, CFG_W'($urandom_range(41, 300)));
        end else begin
          write_reg(REG_RADIUS, CFG_W'($urandom_range(0, 1023)));
        end
        if ($urandom_range(1) == 1) begin
          ang = ANGLE_STEP * $urandom_range(0, 8) + $urandom_range(0, 2) - 1;
          if (ang < 0) begin
            ang = 0;
          end
          write_reg(REG_ARC_ANGLE, CFG_W'(ang));
        end else begin
          write_reg(REG_ARC_ANGLE, CFG_W'($urandom_range(0, 1023)));
        end
      end
      if ($urandom_range(99) < 5) begin
        send_item(1'b1, 1'b0, 8'h00);
      end
      send_item(1'b1, 1'b0, 8'h00);
      steps = 0;
      while (walk_on && steps < 80) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          break;
        end else if (pick < 6) begin
          write_reg(REG_ARC_ANGLE, CFG_W'($urandom_range(0, 1023)));
        end
        send_item(1'b0, 1'b0, 8'h00);
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_item(1'b0, 1'b0, 8'h00);
    end

    // Let the last points drain, then report.
    in_valid <= 1'b0;
    while (queued_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("midpoint_arc_rasterizer_unit regression: pass");
    end else begin
      $display("midpoint_arc_rasterizer_unit regression: fail");
    end
    $finish;
  end

  // Result side stalls at random, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < STALL_PCT);
  end

  // Compare every result transfer with the oldest queued point.
  always @(posedge clk) begin
    arc_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (queued_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, point_x, point_y);
        fail_count++;
      end else begin
        want = queued_points.pop_front();
        if (point_x !== want.px) begin
          $display("%0t: point_x expected %0d got %0d", $time, want.px, point_x);
          fail_count++;
        end
        if (point_y !== want.py) begin
          $display("%0t: point_y expected %0d got %0d", $time, want.py, point_y);
          fail_count++;
        end
        if (point_valid !== want.pv) begin
          $display("%0t: point_valid expected %0b got %0b", $time, want.pv, point_valid);
          fail_count++;
        end
        if (last_of_step !== want.last) begin
          $display("%0t: last_of_step expected %0b got %0b", $time, want.last, last_of_step);
          fail_count++;
        end
        if (arc_done !== want.done) begin
          $display("%0t: arc_done expected %0b got %0b", $time, want.done, arc_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= DOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, DOG_LIMIT);
      $display("midpoint_arc_rasterizer_unit regression: fail");
      $finish;
    end
  end

endmodule
